FILE: hdl/bama_pkg.sv
// Shared types, constants and helper functions for the block availability map allocator.
// Used by bama_seq and block_availability_map_allocator; no dependencies of its own.
package bama_pkg;

  localparam int TRACKS      = 35;
  localparam int MAX_SECTORS = 21;
  localparam int BAM_TRACK   = 18;

  localparam int MAP_W  = 24;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = $clog2(TRACKS);
  localparam int TRK_W  = $clog2(TRACKS + 1);
  localparam int RTRK_W = 6;
  localparam int RSEC_W = 5;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [MAP_W-1:0] map;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [23:0] load_bitmap;
    logic [4:0]  load_count;
    logic [7:0]  sector;
    logic [7:0]  track;
    logic [1:0]  kind;
  } item_t;

  typedef struct packed {
    logic              ok;
    logic [RTRK_W-1:0] got_track;
    logic [RSEC_W-1:0] got_sector;
  } result_t;

  // Sectors per track by zone, capped at MAX_SECTORS; zero outside 1 to 40.
  function automatic logic [CNT_W-1:0] track_size(input logic [TRK_W-1:0] t);
    int n;
    n = 0;
    if (t >= 1 && t <= 17) begin
      n = 21;
    end else if (t >= 18 && t <= 24) begin
      n = 19;
    end else if (t >= 25 && t <= 30) begin
      n = 18;
    end else if (t >= 31 && t <= 40) begin
      n = 17;
    end
    if (n > MAX_SECTORS) begin
      n = MAX_SECTORS;
    end
    return CNT_W'(n);
  endfunction

  // Bits below the sector count of a track.
  function automatic logic [MAP_W-1:0] sector_mask(input logic [CNT_W-1:0] n);
    logic [MAP_W:0] one_hot;
    one_hot = (MAP_W + 1)'(1) << n;
    return MAP_W'(one_hot - (MAP_W + 1)'(1));
  endfunction

  // Entry contents after reset for the track stored at index idx.
  function automatic entry_t reset_entry(input logic [IDX_W-1:0] idx);
    entry_t           e;
    logic [TRK_W-1:0] t;
    t       = TRK_W'(idx) + TRK_W'(1);
    e.count = track_size(t);
    e.map   = '1;
    if (t == BAM_TRACK) begin
      e.count      = (e.count >= CNT_W'(2)) ? e.count - CNT_W'(2) : '0;
      e.map[1:0]   = 2'b00;
    end
    return e;
  endfunction

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [RSEC_W-1:0] lowest_bit(input logic [MAP_W-1:0] v);
    logic [RSEC_W-1:0] pos;
    pos = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = RSEC_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

FILE: hdl/bama_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module bama_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bama_seq.sv
// Request sequencer: scans and updates the per-track map memory, one entry read per cycle.
// Depends on bama_pkg and bama_ram.
module bama_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  bama_pkg::item_t         item,
  input  logic [5:0]              reserved_track,
  input  logic                    take,
  output logic                    ready,
  output logic                    done,
  output bama_pkg::result_t       result
);
  import bama_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_FREE_CHK = 2'd1;
  localparam logic [1:0] ST_SCAN     = 2'd2;
  localparam logic [1:0] ST_FINISH   = 2'd3;

  logic [1:0]        state, state_next;
  logic [TRK_W-1:0]  scan_idx, scan_idx_next;
  logic              chk_valid, chk_valid_next;
  logic [IDX_W-1:0]  chk_idx, chk_idx_next;
  logic [IDX_W-1:0]  trk_idx, trk_idx_next;
  logic [RSEC_W-1:0] sec_q, sec_q_next;
  result_t           res, res_next;
  logic [TRACKS-1:0] valid_bits;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [IDX_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;

  logic [IDX_W-1:0]  cur_idx;
  entry_t            cur;
  logic [TRK_W-1:0]  chk_trk;
  logic [MAP_W-1:0]  avail;
  logic [RSEC_W-1:0] low_sec;
  logic              eligible;
  logic              in_trk_ok;
  logic [IDX_W-1:0]  in_idx;
  logic [CNT_W-1:0]  in_size;
  logic [MAP_W-1:0]  free_bit;

  bama_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TRACKS)
  ) u_map_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Entries never written since reset read as their reset contents.
  assign cur_idx = (state == ST_SCAN) ? chk_idx : trk_idx;
  assign cur     = valid_bits[cur_idx] ? entry_t'(rdata) : reset_entry(cur_idx);

  assign chk_trk  = TRK_W'(chk_idx) + TRK_W'(1);
  assign avail    = cur.map & sector_mask(track_size(chk_trk));
  assign low_sec  = lowest_bit(avail);
  assign eligible = ({{(8 - TRK_W){1'b0}}, chk_trk} != {2'b00, reserved_track}) &&
                    (cur.count != '0) && (avail != '0);

  assign in_trk_ok = (item.track >= 8'd1) && (item.track <= 8'(TRACKS));
  assign in_idx    = IDX_W'(item.track - 8'd1);
  assign in_size   = in_trk_ok ? track_size(TRK_W'(item.track)) : '0;
  assign free_bit  = MAP_W'(1) << sec_q;

  assign ready  = (state == ST_IDLE);
  assign done   = (state == ST_FINISH);
  assign result = res;

  always_comb begin
    state_next     = state;
    scan_idx_next  = scan_idx;
    chk_valid_next = chk_valid;
    chk_idx_next   = chk_idx;
    trk_idx_next   = trk_idx;
    sec_q_next     = sec_q;
    res_next       = res;
    we             = 1'b0;
    waddr          = cur_idx;
    wdata          = cur;
    raddr          = in_idx;

    case (state)
      ST_IDLE: begin
        if (start) begin
          res_next = '0;
          case (item.kind)
            KIND_ALLOC: begin
              scan_idx_next  = '0;
              chk_valid_next = 1'b0;
              state_next     = ST_SCAN;
            end
            KIND_FREE: begin
              if (in_trk_ok && (item.sector < {3'b000, in_size})) begin
                trk_idx_next = in_idx;
                sec_q_next   = RSEC_W'(item.sector);
                state_next   = ST_FREE_CHK;
              end else begin
                state_next = ST_FINISH;
              end
            end
            KIND_LOAD: begin
              if (in_trk_ok) begin
                we          = 1'b1;
                waddr       = in_idx;
                wdata.count = item.load_count;
                wdata.map   = item.load_bitmap;
                res_next.ok = 1'b1;
              end
              state_next = ST_FINISH;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_FREE_CHK: begin
        res_next.ok = 1'b1;
        if ((cur.map & free_bit) == '0) begin
          we        = 1'b1;
          waddr     = trk_idx;
          wdata.map = cur.map | free_bit;
          if (cur.count != '1) begin
            wdata.count = cur.count + CNT_W'(1);
          end
        end
        state_next = ST_FINISH;
      end

      ST_SCAN: begin
        // One read is issued per cycle while the entry read in the previous cycle is checked.
        raddr          = scan_idx[IDX_W-1:0];
        chk_valid_next = (scan_idx != TRK_W'(TRACKS));
        chk_idx_next   = scan_idx[IDX_W-1:0];
        if (scan_idx != TRK_W'(TRACKS)) begin
          scan_idx_next = scan_idx + TRK_W'(1);
        end
        if (chk_valid) begin
          if (eligible) begin
            we                  = 1'b1;
            waddr               = chk_idx;
            wdata.count         = cur.count - CNT_W'(1);
            wdata.map           = cur.map & ~(MAP_W'(1) << low_sec);
            res_next.ok         = 1'b1;
            res_next.got_track  = RTRK_W'(chk_trk);
            res_next.got_sector = low_sec;
            state_next          = ST_FINISH;
          end else if (chk_idx == IDX_W'(TRACKS - 1)) begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chk_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= chk_valid_next;
      if (we) begin
        valid_bits[waddr] <= 1'b1;
      end
    end
    scan_idx <= scan_idx_next;
    chk_idx  <= chk_idx_next;
    trk_idx  <= trk_idx_next;
    sec_q    <= sec_q_next;
    res      <= res_next;
  end

endmodule

FILE: hdl/block_availability_map_allocator.sv
// Top level of the block availability map allocator: stream ports, reserved-track register
// and result register. Depends on bama_pkg and bama_seq.
//
// One request is handled at a time. An allocate request scans the track map memory one entry
// per cycle and stops at the first track that has a free sector; free and load requests do not
// scan. The result sits in an output register, so the next request is accepted while it waits
// to be taken. After reset every track reads as its formatted state (track 18 holding two used
// sectors) with no clearing pass, and requests are accepted from the first cycle.
module block_availability_map_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // track[7:0], sector[15:8], load_count[20:16],
                                 // load_bitmap[44:21], zero fill[47:45]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // got_track[5:0], got_sector[10:6], zero fill[15:11]
  output logic [0:0]  m_tuser,   // ok[0]
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);
  import bama_pkg::*;

  logic [5:0] reserved_trk;
  item_t      item;
  result_t    seq_res;
  result_t    out_res;
  logic       seq_ready;
  logic       seq_done;
  logic       take;
  logic       start;

  assign item.kind        = s_tuser;
  assign item.track       = s_tdata[7:0];
  assign item.sector      = s_tdata[15:8];
  assign item.load_count  = s_tdata[20:16];
  assign item.load_bitmap = s_tdata[44:21];

  assign s_tready = seq_ready;
  assign start    = s_tvalid && seq_ready;
  assign take     = seq_done && (!m_tvalid || m_tready);

  bama_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .reserved_track(reserved_trk),
    .take          (take),
    .ready         (seq_ready),
    .done          (seq_done),
    .result        (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_trk <= 6'(BAM_TRACK);
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        reserved_trk <= cfg_wdata;
      end
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (take) begin
      out_res <= seq_res;
    end
  end

  assign m_tdata = {5'b00000, out_res.got_sector, out_res.got_track};
  assign m_tuser = out_res.ok;

endmodule

FILE: tb/tb_block_availability_map_allocator.sv
// Self-checking testbench for block_availability_map_allocator: drives allocate, free and load
// requests, predicts each reply from its own copy of the track map, and compares field by field.
// Depends on bama_pkg and the allocator RTL.
module tb_block_availability_map_allocator;
  import bama_pkg::*;

  localparam int LIMIT = 600000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Tracks the expected free-sector counts and maps, and the replies still owed by the block.
  class bam_tracker;
    logic [CNT_W-1:0] free_cnt [TRACKS];
    logic [MAP_W-1:0] free_map [TRACKS];
    logic [5:0]       skip_track;
    result_t          replies_due [$];
    int               errors;
    int               shown;

    function new();
      for (int i = 0; i < TRACKS; i++) begin
        free_cnt[i] = CNT_W'(zone_size(i + 1));
        free_map[i] = '1;
      end
      free_cnt[BAM_TRACK - 1]      = free_cnt[BAM_TRACK - 1] - CNT_W'(2);
      free_map[BAM_TRACK - 1][1:0] = 2'b00;
      skip_track = 6'(BAM_TRACK);
      errors     = 0;
      shown      = 0;
    endfunction

    function int zone_size(int t);
      int n;
      if (t >= 1 && t <= 17) begin
        n = 21;
      end else if (t >= 18 && t <= 24) begin
        n = 19;
      end else if (t >= 25 && t <= 30) begin
        n = 18;
      end else if (t >= 31 && t <= 40) begin
        n = 17;
      end else begin
        n = 0;
      end
      return (n > MAX_SECTORS) ? MAX_SECTORS : n;
    endfunction

    function void set_skip(logic [5:0] v);
      skip_track = v;
    endfunction

    function result_t predict_reply(item_t rq);
      result_t r;
      bit      hit;
      int      n;
      int      trk;
      r   = '0;
      hit = 1'b0;
      trk = rq.track;
      case (rq.kind)
        KIND_ALLOC: begin
          // First fit: tracks whose count says empty are skipped, as is the reserved one.
          for (int t = 1; t <= TRACKS && !hit; t++) begin
            if (t != int'(skip_track) && free_cnt[t - 1] != '0) begin
              n = zone_size(t);
              for (int s = 0; s < n && !hit; s++) begin
                if (free_map[t - 1][s]) begin
                  free_map[t - 1][s] = 1'b0;
                  free_cnt[t - 1]    = free_cnt[t - 1] - CNT_W'(1);
                  hit          = 1'b1;
                  r.ok         = 1'b1;
                  r.got_track  = RTRK_W'(t);
                  r.got_sector = RSEC_W'(s);
                end
              end
            end
          end
        end
        KIND_FREE: begin
          if (trk >= 1 && trk <= TRACKS && int'(rq.sector) < zone_size(trk)) begin
            r.ok = 1'b1;
            if (!free_map[trk - 1][rq.sector]) begin
              free_map[trk - 1][rq.sector] = 1'b1;
              if (free_cnt[trk - 1] != '1) begin
                free_cnt[trk - 1] = free_cnt[trk - 1] + CNT_W'(1);
              end
            end
          end
        end
        KIND_LOAD: begin
          if (trk >= 1 && trk <= TRACKS) begin
            free_cnt[trk - 1] = rq.load_count;
            free_map[trk - 1] = rq.load_bitmap;
            r.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_request(item_t rq);
      result_t r;
      r = predict_reply(rq);
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected reply: ok=%0d track=%0d sector=%0d",
                   got.ok, got.got_track, got.got_sector);
        end
        return;
      end
      want = replies_due.pop_front();
      if (got.ok !== want.ok || got.got_track !== want.got_track ||
          got.got_sector !== want.got_sector) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display({"reply mismatch: expected ok=%0d track=%0d sector=%0d,",
                    " got ok=%0d track=%0d sector=%0d"},
                   want.ok, want.got_track, want.got_sector,
                   got.ok, got.got_track, got.got_sector);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we    = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  bam_tracker sb = new();
  int         sent       = 0;
  int         src_idle   = 0;
  int         sink_stall = 0;
  bit         sink_hold  = 1'b0;
  int         cycles     = 0;

  block_availability_map_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled with the values they held at the edge.
  always @(posedge clk) begin : monitor
    item_t   seen;
    result_t back;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.kind        = s_tuser;
        seen.track       = s_tdata[7:0];
        seen.sector      = s_tdata[15:8];
        seen.load_count  = s_tdata[20:16];
        seen.load_bitmap = s_tdata[44:21];
        sb.note_request(seen);
      end
      if (m_tvalid && m_tready) begin
        back.ok         = m_tuser[0];
        back.got_track  = m_tdata[5:0];
        back.got_sector = m_tdata[10:6];
        sb.check_reply(back);
      end
    end
    m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall);
  end

  function automatic item_t request(int kind, int trk, int sec, int cnt, logic [23:0] map);
    item_t q;
    q.kind        = 2'(kind);
    q.track       = 8'(trk);
    q.sector      = 8'(sec);
    q.load_count  = 5'(cnt);
    q.load_bitmap = map;
    return q;
  endfunction

  task automatic send_request(item_t rq);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, rq.load_bitmap, rq.load_count, rq.sector, rq.track};
    s_tuser  <= rq.kind;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // The register is only written once the block has handed back every reply.
  task automatic set_reserved(logic [5:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0) begin
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_skip(v);
  endtask

  task automatic hold_sink(int n);
    sink_hold = 1'b1;
    repeat (n) @(posedge clk);
    sink_hold = 1'b0;
  endtask

  task automatic run_random(int n);
    int          target;
    int          r;
    int          t;
    int          k;
    int          sz;
    logic [23:0] m;
    target = sent + n;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_request(request($urandom_range(3), $urandom_range(255), $urandom_range(255),
                             $urandom_range(21), 24'($urandom)));
      end else if (r < 16) begin
        // A track loaded close to full, then freed sector by sector so the count saturates.
        t = $urandom_range(1, TRACKS);
        send_request(request(KIND_LOAD, t, 0, $urandom_range(15, 21), '0));
        k = $urandom_range(8, 16);
        for (int i = 0; i < k; i++) begin
          send_request(request(KIND_FREE, t, i, 0, '0));
        end
        repeat ($urandom_range(1, 3)) send_request(request(KIND_ALLOC, 0, 0, 0, '0));
      end else if (r < 21) begin
        // Empty the whole map so allocation runs into a full disk, then give a few back.
        for (int i = 1; i <= TRACKS; i++) begin
          send_request(request(KIND_LOAD, i, 0, 0, '0));
        end
        repeat ($urandom_range(2, 4)) send_request(request(KIND_ALLOC, 0, 0, 0, '0));
        repeat ($urandom_range(1, 4)) begin
          t = $urandom_range(1, TRACKS);
          send_request(request(KIND_FREE, t, $urandom_range(0, sb.zone_size(t) - 1), 0, '0));
        end
        repeat ($urandom_range(1, 5)) send_request(request(KIND_ALLOC, 0, 0, 0, '0));
      end else if (r < 30) begin
        // Counts and maps that disagree with each other.
        t  = $urandom_range(1, TRACKS);
        sz = sb.zone_size(t);
        case ($urandom_range(2))
          0: send_request(request(KIND_LOAD, t, 0, $urandom_range(1, 21), '0));
          1: send_request(request(KIND_LOAD, t, 0, 0, 24'($urandom)));
          default: begin
            m = 24'($urandom) & (24'hFFFFFF << sz);
            send_request(request(KIND_LOAD, t, 0, $urandom_range(1, 21), m));
          end
        endcase
        repeat ($urandom_range(1, 3)) send_request(request(KIND_ALLOC, 0, 0, 0, '0));
      end else begin
        k  = $urandom_range(99);
        t  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, TRACKS);
        sz = sb.zone_size(t);
        if (k < 50) begin
          send_request(request(KIND_ALLOC, $urandom_range(255), $urandom_range(255), 0, '0));
        end else if (k < 80) begin
          if (sz == 0 || $urandom_range(7) == 0) begin
            send_request(request(KIND_FREE, t, $urandom_range(255), 0, '0));
          end else begin
            send_request(request(KIND_FREE, t, $urandom_range(0, sz - 1), 0, '0));
          end
        end else begin
          m = $urandom_range(1) ? 24'($urandom) : 24'($urandom & $urandom & $urandom);
          send_request(request(KIND_LOAD, t, 0, $urandom_range(21), m));
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [5:0] reserved_plan [8];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the directory track reserved as after reset.
    send_request(request(KIND_ALLOC, 0, 0, 0, '0));
    send_request(request(KIND_ALLOC, 0, 0, 0, '0));
    send_request(request(KIND_FREE, 1, 0, 0, '0));
    send_request(request(KIND_FREE, 1, 0, 0, '0));
    send_request(request(KIND_FREE, 0, 0, 0, '0));
    send_request(request(KIND_FREE, 36, 0, 0, '0));
    send_request(request(KIND_FREE, 255, 255, 0, '0));
    send_request(request(KIND_FREE, 1, 21, 0, '0));
    send_request(request(KIND_FREE, 35, 16, 0, '0));
    send_request(request(KIND_FREE, 35, 17, 0, '0));
    send_request(request(KIND_LOAD, 0, 0, 21, 24'hFFFFFF));
    send_request(request(KIND_LOAD, 36, 0, 21, 24'hFFFFFF));
    send_request(request(KIND_LOAD, 1, 0, 0, 24'hFFFFFF));
    send_request(request(KIND_LOAD, 2, 0, 5, '0));
    send_request(request(KIND_ALLOC, 0, 0, 0, '0));
    send_request(request(KIND_LOAD, 35, 0, 21, 24'hFFFFFF));
    send_request(request(KIND_LOAD, 18, 0, 3, 24'h000003));
    send_request(request(KIND_FREE, 18, 18, 0, '0));
    send_request(request(KIND_FREE, 18, 19, 0, '0));
    send_request(request(KIND_UNUSED, 255, 255, 21, 24'hFFFFFF));
    send_request(request(KIND_LOAD, 3, 0, 21, 24'h800000));
    send_request(request(KIND_ALLOC, 0, 0, 0, '0));

    reserved_plan = '{6'd1, 6'd35, 6'd0, 6'd63, 6'd18, 6'($urandom_range(1, 35)),
                      6'($urandom_range(63)), 6'd2};
    for (int ph = 0; ph < 8; ph++) begin
      set_reserved(reserved_plan[ph]);
      case (ph % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 53; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 53; end
        default: begin src_idle = 11; sink_stall = 11; end
      endcase
      // A long receiver hold-off while requests keep coming, to back the block up.
      if (ph == 4) begin
        fork
          hold_sink(400);
        join_none
      end
      run_random(190);
    end
    s_tvalid <= 1'b0;

    while (sb.replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("[block_availability_map_allocator] OK");
    end else begin
      $display("[block_availability_map_allocator] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[block_availability_map_allocator] ERROR");
    $finish;
  end

endmodule
